[rtl/wav_header_parser_top_defines.svh]
// assertion macros used by the checker file
`ifndef WAV_HEADER_PARSER_TOP_DEFINES_SVH
`define WAV_HEADER_PARSER_TOP_DEFINES_SVH

// implication checked on every rising clock edge out of reset
`define WHP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define WHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/whp_pkg.sv]
// types and constants of the wave header parser
package whp_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned ERR_W      = 3;
    localparam int unsigned HALF_W     = 16;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned POS_W      = 6;
    localparam int unsigned PHASE_W    = 2;
    localparam int unsigned OUT_DATA_W = 112;
    localparam int unsigned OUT_PAD_W  = 5;

    localparam logic [KIND_W-1:0] KIND_HEADER  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DISCARD = 3'd4;

    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NOT_RIFF = 3'd1;
    localparam logic [ERR_W-1:0] ERR_NOT_WAVE = 3'd2;
    localparam logic [ERR_W-1:0] ERR_NO_FMT   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_FMT_SIZE = 3'd4;
    localparam logic [ERR_W-1:0] ERR_NOT_PCM  = 3'd5;
    localparam logic [ERR_W-1:0] ERR_NO_DATA  = 3'd6;

    localparam logic [PHASE_W-1:0] PH_HEADER  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DISCARD = 2'd2;

    localparam logic [POS_W-1:0] POS_RIFF     = 6'd3;
    localparam logic [POS_W-1:0] POS_WAVE     = 6'd11;
    localparam logic [POS_W-1:0] POS_FMT      = 6'd15;
    localparam logic [POS_W-1:0] POS_FMT_SIZE = 6'd19;
    localparam logic [POS_W-1:0] POS_FORMAT   = 6'd21;
    localparam logic [POS_W-1:0] POS_CHANNELS = 6'd23;
    localparam logic [POS_W-1:0] POS_RATE     = 6'd27;
    localparam logic [POS_W-1:0] POS_BITS     = 6'd35;
    localparam logic [POS_W-1:0] POS_DATA     = 6'd39;
    localparam logic [POS_W-1:0] POS_SIZE     = 6'd43;

    localparam logic [WORD_W-1:0] TAG_RIFF       = 32'h4646_4952;
    localparam logic [WORD_W-1:0] TAG_WAVE       = 32'h4556_4157;
    localparam logic [WORD_W-1:0] TAG_FMT        = 32'h2074_6D66;
    localparam logic [WORD_W-1:0] TAG_DATA       = 32'h6174_6164;
    localparam logic [WORD_W-1:0] FMT_CHUNK_SIZE = 32'd16;
    localparam logic [HALF_W-1:0] FORMAT_PCM     = 16'd1;

    typedef struct packed {
        logic              sof;
        logic [BYTE_W-1:0] data;
    } in_beat_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] payload;
        logic              last;
        logic [ERR_W-1:0]  err;
        logic [HALF_W-1:0] channels;
        logic [WORD_W-1:0] rate;
        logic [HALF_W-1:0] bits;
        logic [WORD_W-1:0] size;
    } result_t;

endpackage

[rtl/whp_in_stage.sv]
// input register for incoming file bytes
module whp_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  whp_pkg::in_beat_t in_beat,
    output logic              held_valid,
    input  logic              held_ready,
    output whp_pkg::in_beat_t held_beat
);
    import whp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;

    assign in_ready   = !valid_reg || held_ready;
    assign held_valid = valid_reg;
    assign held_beat  = beat_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_reg <= in_beat;
        end
    end

endmodule

[rtl/whp_parse.sv]
// header parse state and per-byte result logic
module whp_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  whp_pkg::in_beat_t beat,
    output whp_pkg::result_t  result
);
    import whp_pkg::*;

    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [PHASE_W-1:0] phase_reg,  phase_next;
    logic [WORD_W-1:0]  shift_reg,  shift_next;
    logic [HALF_W-1:0]  chan_reg,   chan_next;
    logic [WORD_W-1:0]  rate_reg,   rate_next;
    logic [HALF_W-1:0]  bits_reg,   bits_next;
    logic [WORD_W-1:0]  size_reg,   size_next;
    logic [WORD_W-1:0]  remain_reg, remain_next;
    logic [ERR_W-1:0]   err_reg,    err_next;

    logic [POS_W-1:0]   pos_eff;
    logic [PHASE_W-1:0] phase_eff;
    logic [WORD_W-1:0]  shift_eff;
    logic [WORD_W-1:0]  remain_eff;
    logic [WORD_W-1:0]  sh;
    logic [HALF_W-1:0]  half;
    logic [ERR_W-1:0]   fail;
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  pay;
    logic               last;

    always_comb
    begin
        pos_eff    = beat.sof ? '0 : pos_reg;
        phase_eff  = beat.sof ? PH_HEADER : phase_reg;
        shift_eff  = beat.sof ? '0 : shift_reg;
        remain_eff = beat.sof ? '0 : remain_reg;
        chan_next  = beat.sof ? '0 : chan_reg;
        rate_next  = beat.sof ? '0 : rate_reg;
        bits_next  = beat.sof ? '0 : bits_reg;
        size_next  = beat.sof ? '0 : size_reg;
        err_next   = beat.sof ? ERR_NONE : err_reg;

        pos_next    = pos_eff;
        phase_next  = phase_eff;
        shift_next  = shift_eff;
        remain_next = remain_eff;
        sh          = {beat.data, shift_eff[WORD_W-1:BYTE_W]};
        half        = sh[WORD_W-1:HALF_W];
        fail        = ERR_NONE;
        kind        = KIND_DISCARD;
        pay         = '0;
        last        = 1'b0;

        if (phase_eff == PH_HEADER)
        begin
            shift_next = sh;
            kind       = KIND_HEADER;
            case (pos_eff)
                POS_RIFF:     if (sh != TAG_RIFF) fail = ERR_NOT_RIFF;
                POS_WAVE:     if (sh != TAG_WAVE) fail = ERR_NOT_WAVE;
                POS_FMT:      if (sh != TAG_FMT) fail = ERR_NO_FMT;
                POS_FMT_SIZE: if (sh != FMT_CHUNK_SIZE) fail = ERR_FMT_SIZE;
                POS_FORMAT:   if (half != FORMAT_PCM) fail = ERR_NOT_PCM;
                POS_CHANNELS: chan_next = half;
                POS_RATE:     rate_next = sh;
                POS_BITS:     bits_next = half;
                POS_DATA:     if (sh != TAG_DATA) fail = ERR_NO_DATA;
                POS_SIZE:
                begin
                    size_next   = sh;
                    remain_next = sh;
                    kind        = KIND_ACCEPT;
                    phase_next  = (sh != '0) ? PH_PAYLOAD : PH_DISCARD;
                end
                default: ;
            endcase
            if (fail != ERR_NONE)
            begin
                err_next   = fail;
                phase_next = PH_DISCARD;
                kind       = KIND_ERROR;
            end
            else if (pos_eff < POS_SIZE)
            begin
                pos_next = pos_eff + POS_W'(1);
            end
        end
        else if (phase_eff == PH_PAYLOAD)
        begin
            kind = KIND_PAYLOAD;
            pay  = beat.data;
            if (remain_eff <= WORD_W'(1))
            begin
                last        = 1'b1;
                remain_next = '0;
                phase_next  = PH_DISCARD;
            end
            else
            begin
                remain_next = remain_eff - WORD_W'(1);
            end
        end

        result.kind     = kind;
        result.payload  = pay;
        result.last     = last;
        result.err      = err_next;
        result.channels = chan_next;
        result.rate     = rate_next;
        result.bits     = bits_next;
        result.size     = size_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            phase_reg  <= PH_HEADER;
            shift_reg  <= '0;
            chan_reg   <= '0;
            rate_reg   <= '0;
            bits_reg   <= '0;
            size_reg   <= '0;
            remain_reg <= '0;
            err_reg    <= ERR_NONE;
        end
        else if (fire)
        begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            shift_reg  <= shift_next;
            chan_reg   <= chan_next;
            rate_reg   <= rate_next;
            bits_reg   <= bits_next;
            size_reg   <= size_next;
            remain_reg <= remain_next;
            err_reg    <= err_next;
        end
    end

endmodule

[rtl/whp_out_stage.sv]
// result register driving the output stream
module whp_out_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           res_valid,
    output logic                           res_ready,
    input  whp_pkg::result_t               res,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [whp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast,
    output logic [whp_pkg::KIND_W-1:0]     m_axis_tuser
);
    import whp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign res_ready     = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, res_reg.size, res_reg.bits, res_reg.rate,
                            res_reg.channels, res_reg.err, res_reg.payload};
    assign m_axis_tlast  = res_reg.last;
    assign m_axis_tuser  = res_reg.kind;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_ready)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

[rtl/wav_header_parser_top.sv]
// top level of the wave header parser
//
// channel  dir  data bits                                    user bits       last
// s_axis   in   [7:0] data_byte                              [0] start_of_file  -
// m_axis   out  [7:0] payload_byte [10:8] error_code          [2:0] item_kind  last_payload
//               [26:11] channel_count [58:27] sample_rate
//               [74:59] sample_bits [106:75] data_size
//
// one beat in and one result out per cycle unless the output stalls; a beat
// passes the input register, then the result register, and each holds one beat, so a stalled
// output still lets one more input beat in
// reset clears all parse state and both stage valids; a start-of-file beat
// restarts the parse at any time
module wav_header_parser_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [whp_pkg::BYTE_W-1:0]     s_axis_tdata,  // data_byte
    input  logic                           s_axis_tuser,  // start_of_file
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [whp_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // payload_byte, error_code,
                                                          // channel_count, sample_rate,
                                                          // sample_bits, data_size, pad
    output logic                           m_axis_tlast,  // last_payload
    output logic [whp_pkg::KIND_W-1:0]     m_axis_tuser   // item_kind
);
    import whp_pkg::*;

    in_beat_t in_beat;
    in_beat_t held_beat;
    logic     held_valid;
    logic     held_ready;
    result_t  res;

    assign in_beat.sof  = s_axis_tuser;
    assign in_beat.data = s_axis_tdata;

    whp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_beat    (in_beat),
        .held_valid (held_valid),
        .held_ready (held_ready),
        .held_beat  (held_beat)
    );

    whp_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (held_valid && held_ready),
        .beat   (held_beat),
        .result (res)
    );

    whp_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (held_valid),
        .res_ready     (held_ready),
        .res           (res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[rtl/whp_checker.sv]
// port-level checks of the wave header parser and their bind
`include "wav_header_parser_top_defines.svh"

module whp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [whp_pkg::BYTE_W-1:0]     s_axis_tdata,
    input logic                           s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [whp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast,
    input logic [whp_pkg::KIND_W-1:0]     m_axis_tuser
);
    import whp_pkg::*;

    `WHP_ASSERT_NEXT(a_in_hold, s_axis_tvalid && !s_axis_tready,
        s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser),
        "input beat changed while stalled")
    `WHP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
        "result changed while stalled")
    `WHP_ASSERT_IMPLY(a_last_is_payload, m_axis_tvalid && m_axis_tlast,
        m_axis_tuser == KIND_PAYLOAD, "last flag on a non-payload beat")
    `WHP_ASSERT_IMPLY(a_error_has_code, m_axis_tvalid && m_axis_tuser == KIND_ERROR,
        m_axis_tdata[10:8] != ERR_NONE, "error beat without error code")
    `WHP_ASSERT_IMPLY(a_payload_zero, m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD,
        m_axis_tdata[7:0] == '0 && !m_axis_tlast, "payload field set outside payload beat")

endmodule

bind wav_header_parser_top whp_checker u_whp_checker (.*);

[sim/wav_header_parser_top_test.sv]
// testbench for the wave header parser: byte stream files checked beat by beat
`timescale 1ns / 100ps

module wav_header_parser_top_test;
    import whp_pkg::*;

    localparam int ITEM_TARGET = 1850;
    localparam int LONG_HOLD   = 300;
    localparam int STUCK_LIMIT = 2000;
    localparam int DRAIN_TAIL  = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic [KIND_W-1:0]     m_axis_tuser;

    // parser state as predicted
    logic [POS_W-1:0]   hdr_pos;
    logic [PHASE_W-1:0] stream_phase;
    logic [WORD_W-1:0]  shift_word;
    logic [HALF_W-1:0]  cap_channels;
    logic [WORD_W-1:0]  cap_rate;
    logic [HALF_W-1:0]  cap_bits;
    logic [WORD_W-1:0]  cap_size;
    logic [WORD_W-1:0]  bytes_left;
    logic [ERR_W-1:0]   cap_err;

    result_t      parse_results_q[$];
    result_t      want_result;
    logic [7:0]   file_hdr[0:43];
    int           beats_sent;
    int           mismatches;
    int           stuck_cycles;
    int           stall_left;
    int           hold_requests;
    int           holds_taken;
    bit           tx_quiet;
    bit           rx_quiet;

    wav_header_parser_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic result_t parse_byte(logic [BYTE_W-1:0] b, logic sof);
        result_t           r;
        logic [ERR_W-1:0]  code;
        logic [HALF_W-1:0] half;
        r = '0;
        code = ERR_NONE;
        if (sof)
        begin
            hdr_pos      = '0;
            stream_phase = PH_HEADER;
            shift_word   = '0;
            cap_channels = '0;
            cap_rate     = '0;
            cap_bits     = '0;
            cap_size     = '0;
            bytes_left   = '0;
            cap_err      = ERR_NONE;
        end
        if (stream_phase == PH_HEADER)
        begin
            shift_word = {b, shift_word[WORD_W-1:BYTE_W]};
            half = shift_word[WORD_W-1:HALF_W];
            r.kind = KIND_HEADER;
            case (hdr_pos)
                POS_RIFF:     if (shift_word != TAG_RIFF) code = ERR_NOT_RIFF;
                POS_WAVE:     if (shift_word != TAG_WAVE) code = ERR_NOT_WAVE;
                POS_FMT:      if (shift_word != TAG_FMT) code = ERR_NO_FMT;
                POS_FMT_SIZE: if (shift_word != FMT_CHUNK_SIZE) code = ERR_FMT_SIZE;
                POS_FORMAT:   if (half != FORMAT_PCM) code = ERR_NOT_PCM;
                POS_CHANNELS: cap_channels = half;
                POS_RATE:     cap_rate = shift_word;
                POS_BITS:     cap_bits = half;
                POS_DATA:     if (shift_word != TAG_DATA) code = ERR_NO_DATA;
                POS_SIZE:
                begin
                    cap_size     = shift_word;
                    bytes_left   = shift_word;
                    r.kind       = KIND_ACCEPT;
                    stream_phase = (shift_word != '0) ? PH_PAYLOAD : PH_DISCARD;
                end
                default: ;
            endcase
            if (code != ERR_NONE)
            begin
                cap_err      = code;
                stream_phase = PH_DISCARD;
                r.kind       = KIND_ERROR;
            end
            else if (hdr_pos < POS_SIZE)
                hdr_pos = hdr_pos + POS_W'(1);
        end
        else if (stream_phase == PH_PAYLOAD)
        begin
            r.kind    = KIND_PAYLOAD;
            r.payload = b;
            if (bytes_left <= WORD_W'(1))
            begin
                r.last       = 1'b1;
                bytes_left   = '0;
                stream_phase = PH_DISCARD;
            end
            else
                bytes_left = bytes_left - WORD_W'(1);
        end
        else
            r.kind = KIND_DISCARD;
        r.err      = cap_err;
        r.channels = cap_channels;
        r.rate     = cap_rate;
        r.bits     = cap_bits;
        r.size     = cap_size;
        return r;
    endfunction

    function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void put_le(int idx, int nbytes, logic [WORD_W-1:0] v);
        for (int k = 0; k < nbytes; k++)
            file_hdr[idx+k] = v[8*k +: 8];
    endfunction

    function automatic void build_header(logic [HALF_W-1:0] ch, logic [WORD_W-1:0] rate,
                                         logic [HALF_W-1:0] bits, logic [WORD_W-1:0] size);
        put_le(0, 4, TAG_RIFF);
        put_le(4, 4, $urandom);
        put_le(8, 4, TAG_WAVE);
        put_le(12, 4, TAG_FMT);
        put_le(16, 4, FMT_CHUNK_SIZE);
        put_le(20, 2, WORD_W'(FORMAT_PCM));
        put_le(22, 2, WORD_W'(ch));
        put_le(24, 4, rate);
        put_le(28, 4, $urandom);
        put_le(32, 2, $urandom);
        put_le(34, 2, WORD_W'(bits));
        put_le(36, 4, TAG_DATA);
        put_le(40, 4, size);
    endfunction

    // flip a random byte of the field that the given error code checks
    function automatic void corrupt_field(logic [ERR_W-1:0] code);
        int first;
        int last_idx;
        case (code)
            ERR_NOT_RIFF: last_idx = int'(POS_RIFF);
            ERR_NOT_WAVE: last_idx = int'(POS_WAVE);
            ERR_NO_FMT:   last_idx = int'(POS_FMT);
            ERR_FMT_SIZE: last_idx = int'(POS_FMT_SIZE);
            ERR_NOT_PCM:  last_idx = int'(POS_FORMAT);
            default:      last_idx = int'(POS_DATA);
        endcase
        first = (code == ERR_NOT_PCM) ? last_idx - 1 : last_idx - 3;
        file_hdr[$urandom_range(first, last_idx)] ^= 8'($urandom_range(1, 255));
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic sof);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= sof;
        do @(posedge clk); while (!s_axis_tready);
        parse_results_q.push_back(parse_byte(b, sof));
        beats_sent++;
    endtask

    task automatic send_header(input bit with_sof, input int upto);
        for (int i = 0; i < upto; i++)
            send_beat(file_hdr[i], with_sof && (i == 0));
    endtask

    task automatic send_payload(input int n);
        repeat (n) send_beat(BYTE_W'($urandom), 1'b0);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (parse_results_q.size() != 0);
    endtask

    // must run first: no start beat after reset
    task automatic test_headerless_start();
        build_header(16'd2, 32'd44100, 16'd16, 32'd3);
        send_header(1'b0, 44);
        send_payload(5);
        wait_drain();
    endtask

    task automatic test_check_failures();
        for (int c = ERR_NOT_RIFF; c <= ERR_NO_DATA; c++)
        begin
            build_header(HALF_W'($urandom), $urandom, HALF_W'($urandom), 32'd4);
            corrupt_field(ERR_W'(c));
            send_header(1'b1, 44);
            send_payload(2);
        end
        wait_drain();
    endtask

    task automatic test_zero_size();
        build_header(16'd1, 32'd8000, 16'd8, 32'd0);
        send_header(1'b1, 44);
        send_payload(4);
        wait_drain();
    endtask

    task automatic test_field_extremes();
        build_header(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_header(1'b1, 44);
        repeat (8)
        begin
            send_beat(8'hFF, 1'b0);
            send_beat(8'h00, 1'b0);
        end
        build_header(16'h0000, 32'h0000_0000, 16'h0000, 32'd1);
        send_header(1'b1, 44);
        send_payload(3);
        wait_drain();
    endtask

    task automatic test_restart();
        build_header(16'd6, 32'd96000, 16'd24, 32'd10);
        send_header(1'b1, 20);
        send_header(1'b1, 44);
        send_payload(4);
        send_header(1'b1, 44);
        send_payload(12);
        wait_drain();
    endtask

    // output held off while the input keeps offering beats
    task automatic test_output_stall();
        hold_requests++;
        build_header(16'd2, 32'd48000, 16'd16, 32'd40);
        send_header(1'b1, 44);
        send_payload(40);
        wait_drain();
    endtask

    task automatic test_random_files();
        int pick;
        int size;
        while (beats_sent < ITEM_TARGET)
        begin
            tx_quiet = ($urandom_range(0, 9) == 0);
            rx_quiet = ($urandom_range(0, 9) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                size = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200)
                                                    : $urandom_range(0, 24);
                build_header(HALF_W'($urandom), $urandom, HALF_W'($urandom), size);
                send_header(1'b1, 44);
                if ($urandom_range(0, 7) == 0)
                    send_payload($urandom_range(0, size));
                else
                    send_payload(size + $urandom_range(0, 3));
            end
            else if (pick < 88)
            begin
                build_header(HALF_W'($urandom), $urandom, HALF_W'($urandom),
                             $urandom_range(0, 8));
                corrupt_field(ERR_W'($urandom_range(ERR_NOT_RIFF, ERR_NO_DATA)));
                if ($urandom_range(0, 3) == 0)
                    send_header(1'b1, $urandom_range(1, 44));
                else
                begin
                    send_header(1'b1, 44);
                    send_payload($urandom_range(0, 3));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 20))
                    send_beat(BYTE_W'($urandom), $urandom_range(0, 7) == 0);
            end
            if ($urandom_range(0, 15) == 0)
                wait_drain();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        hdr_pos       = '0;
        stream_phase  = PH_HEADER;
        shift_word    = '0;
        cap_channels  = '0;
        cap_rate      = '0;
        cap_bits      = '0;
        cap_size      = '0;
        bytes_left    = '0;
        cap_err       = ERR_NONE;
        beats_sent    = 0;
        hold_requests = 0;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_headerless_start();
        test_check_failures();
        test_zero_size();
        test_field_extremes();
        test_restart();
        test_output_stall();
        test_random_files();
        wait_drain();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatches == 0)
            $display("wav_header_parser_top_test: done, clean");
        else
            $display("wav_header_parser_top_test: done, errors");
        $finish;
    end

    // receiver with random stalls and requested long hold-offs
    initial
    begin
        m_axis_tready <= 1'b0;
        stall_left  = 0;
        holds_taken = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_taken)
            begin
                holds_taken = hold_requests;
                stall_left  = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (rx_quiet || $urandom_range(0, 99) < 70)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                          : $urandom_range(9, 39);
            end
        end
    end

    initial
    begin
        mismatches = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (parse_results_q.size() == 0)
                begin
                    $error("result beat with nothing expected, kind %0d", m_axis_tuser);
                    mismatches++;
                end
                else
                begin
                    want_result = parse_results_q.pop_front();
                    check_field("item_kind", WORD_W'(want_result.kind),
                                WORD_W'(m_axis_tuser));
                    check_field("payload_byte", WORD_W'(want_result.payload),
                                WORD_W'(m_axis_tdata[7:0]));
                    check_field("last_payload", WORD_W'(want_result.last),
                                WORD_W'(m_axis_tlast));
                    check_field("error_code", WORD_W'(want_result.err),
                                WORD_W'(m_axis_tdata[10:8]));
                    check_field("channel_count", WORD_W'(want_result.channels),
                                WORD_W'(m_axis_tdata[26:11]));
                    check_field("sample_rate", want_result.rate, m_axis_tdata[58:27]);
                    check_field("sample_bits", WORD_W'(want_result.bits),
                                WORD_W'(m_axis_tdata[74:59]));
                    check_field("data_size", want_result.size, m_axis_tdata[106:75]);
                end
            end
        end
    end

    initial
    begin
        stuck_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("wav_header_parser_top_test: done, errors");
                $finish;
            end
        end
    end

endmodule

[files.f]
+incdir+rtl
rtl/whp_pkg.sv
rtl/whp_in_stage.sv
rtl/whp_parse.sv
rtl/whp_out_stage.sv
rtl/wav_header_parser_top.sv
rtl/whp_checker.sv
sim/wav_header_parser_top_test.sv
